/* design/aed_pkg.sv */
`timescale 1ns / 1ps

package aed_pkg;

    // Queue between the classifier and the result expander.
    localparam int QUEUE_DEPTH = 4;

    // Special bytes of the stream.
    localparam logic [7:0] BYTE_CZ = 8'h1A;
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_SP = 8'h20;

    // Result types.
    localparam logic [1:0] TYPE_CONSOLE  = 2'd0;
    localparam logic [1:0] TYPE_ARGUMENT = 2'd1;
    localparam logic [1:0] TYPE_COMPLETE = 2'd2;

    // Parser modes.
    localparam logic [1:0] MODE_DATA = 2'd0;
    localparam logic [1:0] MODE_NL   = 2'd1;
    localparam logic [1:0] MODE_CZ   = 2'd2;
    localparam logic [1:0] MODE_ANN  = 2'd3;

    // Number of held bytes replayed ahead of the tail result.
    localparam logic [1:0] REPLAY_NONE  = 2'd0;
    localparam logic [1:0] REPLAY_LF    = 2'd1;
    localparam logic [1:0] REPLAY_LF_CZ = 2'd2;

    localparam int NAME_COUNT = 26;
    localparam int NAME_MAX   = 24;
    localparam logic [4:0] POS_MAX = 5'd31;

    // Names are right-justified in each word; byte 0 of a name of length L
    // sits at bit offset 8 * (L - 1).
    localparam logic [NAME_MAX*8-1:0] NAME_STR [NAME_COUNT] = '{
        "breakpoints-invalid", "source", "frame-end", "frames-invalid",
        "pre-commands", "commands", "post-commands", "pre-overload-choice",
        "overload-choice", "post-overload-choice", "pre-instance-choice",
        "instance-choice", "post-instance-choice", "pre-query", "query",
        "post-query", "pre-prompt-for-continue", "prompt-for-continue",
        "post-prompt-for-continue", "pre-prompt", "prompt", "post-prompt",
        "error-begin", "error", "quit", "exited"
    };

    localparam logic [4:0] NAME_LEN [NAME_COUNT] = '{
        5'd19, 5'd6,  5'd9,  5'd14, 5'd12, 5'd8,  5'd13, 5'd19, 5'd15,
        5'd20, 5'd19, 5'd15, 5'd20, 5'd9,  5'd5,  5'd10, 5'd23, 5'd19,
        5'd24, 5'd10, 5'd6,  5'd11, 5'd11, 5'd5,  5'd4,  5'd6
    };

    // One entry of the queue: zero to two replayed bytes and an optional
    // tail result. Every entry produces at least one result.
    typedef struct packed {
        logic [1:0] replay;
        logic       has_tail;
        logic [1:0] tail_type;
        logic [7:0] tail_byte;
        logic [4:0] tail_code;
    } cmd_t;

    // Bit i is set when name i still matches after byte b at position pos.
    function automatic logic [NAME_COUNT-1:0] name_keep(input logic [4:0] pos,
                                                        input logic [7:0] b);
        logic [NAME_COUNT-1:0] keep;
        logic [4:0]            idx;
        keep = '0;
        for (int i = 0; i < NAME_COUNT; i++) begin
            idx = 5'd0;
            if (pos < NAME_LEN[i]) begin
                idx = NAME_LEN[i] - 5'd1 - pos;
                keep[i] = (NAME_STR[i][{idx, 3'b000} +: 8] == b);
            end
        end
        return keep;
    endfunction

    // Lowest-numbered surviving name whose length equals the name length seen.
    function automatic logic [4:0] final_code(input logic [NAME_COUNT-1:0] mask,
                                              input logic [4:0] pos);
        logic [4:0] code;
        code = 5'd0;
        for (int i = NAME_COUNT - 1; i >= 0; i--) begin
            if (mask[i] && (NAME_LEN[i] == pos)) begin
                code = 5'(i + 1);
            end
        end
        return code;
    endfunction

endpackage

/* design/annotation_escape_deframer.sv */
`timescale 1ns / 1ps

// Annotation escape deframer.
// Input channel: in_valid / in_stall with byte_in, one raw byte per item.
// Output channel: out_valid / out_stall with item_type, byte_value,
// annotation_code and last_of_run. An item moves on a rising edge where
// valid is high and stall is low.
// Each input byte gives zero to three results; last_of_run marks the final
// result belonging to one input byte. Carriage returns give no result; held
// newline or control-Z bytes give none until the following byte decides.
// The first result of a byte passes through the command queue and then the output
// register. The input side takes one byte every cycle while the queue is not full;
// the output side gives one result per cycle unless the receiver stalls, so a byte
// with several results, up to three, is absorbed by the command queue until full.
// When the receiver stalls, the output register holds its result and the
// queue fills; in_stall rises once the queue is full.
// Reset clears the parser to data mode, empties the queue and drops any
// pending result.
module annotation_escape_deframer #(
    parameter int QUEUE_DEPTH = aed_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  item_type,
    output logic [7:0]  byte_value,
    output logic [4:0]  annotation_code,
    output logic        last_of_run
);

    logic           full;
    logic           accept;
    logic           push;
    aed_pkg::cmd_t  push_cmd;
    logic           pop;
    logic           head_valid;
    aed_pkg::cmd_t  head;

    // The queue occupancy alone decides whether a byte can be taken.
    assign in_stall = full;
    assign accept   = in_valid && !full;

    // Front: classifies each byte and tracks the annotation name match.
    aed_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .byte_in (byte_in),
        .push    (push),
        .cmd     (push_cmd)
    );

    // Queue of pending result groups between the two sides.
    aed_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .full       (full)
    );

    // Back: expands each group into one to three registered results.
    aed_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .item_type       (item_type),
        .byte_value      (byte_value),
        .annotation_code (annotation_code),
        .last_of_run     (last_of_run)
    );

endmodule

/* design/aed_front.sv */
`timescale 1ns / 1ps

module aed_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         byte_in,
    output logic               push,
    output aed_pkg::cmd_t      cmd
);

    logic [1:0]                     mode_reg, mode_next;
    logic [4:0]                     pos_reg, pos_next;
    logic [aed_pkg::NAME_COUNT-1:0] mask_reg, mask_next;
    logic                           arg_reg, arg_next;

    always_comb begin
        mode_next = mode_reg;
        pos_next  = pos_reg;
        mask_next = mask_reg;
        arg_next  = arg_reg;
        push      = 1'b0;
        cmd       = '0;
        cmd.tail_type = aed_pkg::TYPE_CONSOLE;
        cmd.tail_byte = byte_in;
        cmd.replay    = aed_pkg::REPLAY_NONE;

        if (accept && (byte_in != aed_pkg::BYTE_CR)) begin
            unique case (mode_reg)
                aed_pkg::MODE_DATA:
                begin
                    if (byte_in == aed_pkg::BYTE_LF) begin
                        mode_next = aed_pkg::MODE_NL;
                    end else begin
                        push         = 1'b1;
                        cmd.has_tail = 1'b1;
                    end
                end
                aed_pkg::MODE_NL:
                begin
                    if (byte_in == aed_pkg::BYTE_CZ) begin
                        mode_next = aed_pkg::MODE_CZ;
                    end else begin
                        push       = 1'b1;
                        cmd.replay = aed_pkg::REPLAY_LF;
                        if (byte_in != aed_pkg::BYTE_LF) begin
                            cmd.has_tail = 1'b1;
                            mode_next    = aed_pkg::MODE_DATA;
                        end
                    end
                end
                aed_pkg::MODE_CZ:
                begin
                    if (byte_in == aed_pkg::BYTE_CZ) begin
                        mode_next = aed_pkg::MODE_ANN;
                        pos_next  = 5'd0;
                        mask_next = '1;
                        arg_next  = 1'b0;
                    end else begin
                        push       = 1'b1;
                        cmd.replay = aed_pkg::REPLAY_LF_CZ;
                        if (byte_in == aed_pkg::BYTE_LF) begin
                            mode_next = aed_pkg::MODE_NL;
                        end else begin
                            cmd.has_tail = 1'b1;
                            mode_next    = aed_pkg::MODE_DATA;
                        end
                    end
                end
                aed_pkg::MODE_ANN:
                begin
                    if (byte_in == aed_pkg::BYTE_LF) begin
                        push          = 1'b1;
                        cmd.has_tail  = 1'b1;
                        cmd.tail_type = aed_pkg::TYPE_COMPLETE;
                        cmd.tail_byte = 8'd0;
                        cmd.tail_code = aed_pkg::final_code(mask_reg, pos_reg);
                        mode_next     = aed_pkg::MODE_DATA;
                        pos_next      = 5'd0;
                        mask_next     = '1;
                        arg_next      = 1'b0;
                    end else if (arg_reg) begin
                        push          = 1'b1;
                        cmd.has_tail  = 1'b1;
                        cmd.tail_type = aed_pkg::TYPE_ARGUMENT;
                    end else if (byte_in == aed_pkg::BYTE_SP) begin
                        arg_next = 1'b1;
                    end else begin
                        mask_next = mask_reg & aed_pkg::name_keep(pos_reg, byte_in);
                        if (pos_reg != aed_pkg::POS_MAX) begin
                            pos_next = pos_reg + 5'd1;
                        end
                    end
                end
                default:
                begin
                    mode_next = aed_pkg::MODE_DATA;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg <= aed_pkg::MODE_DATA;
            pos_reg  <= 5'd0;
            mask_reg <= '1;
            arg_reg  <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            mask_reg <= mask_next;
            arg_reg  <= arg_next;
        end
    end

endmodule

/* design/aed_queue.sv */
`timescale 1ns / 1ps

module aed_queue #(
    parameter int QUEUE_DEPTH = aed_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  aed_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output logic               head_valid,
    output aed_pkg::cmd_t      head,
    output logic               full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    aed_pkg::cmd_t     entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head       = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The front must never write into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("aed_queue: push while full");

    // The occupancy never runs past the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("aed_queue: count out of range");

endmodule

/* design/aed_back.sv */
`timescale 1ns / 1ps

module aed_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  aed_pkg::cmd_t      head,
    output logic               pop,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [1:0]         item_type,
    output logic [7:0]         byte_value,
    output logic [4:0]         annotation_code,
    output logic               last_of_run
);

    logic       valid_reg, valid_next;
    logic [1:0] step_reg, step_next;
    logic [1:0] type_reg, type_next;
    logic [7:0] byte_reg, byte_next;
    logic [4:0] code_reg, code_next;
    logic       last_reg, last_next;
    logic       load;

    assign load = !valid_reg || !out_stall;

    always_comb begin
        valid_next = valid_reg;
        step_next  = step_reg;
        type_next  = type_reg;
        byte_next  = byte_reg;
        code_next  = code_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = head_valid;
            if (head_valid) begin
                if (step_reg < head.replay) begin
                    // Replay of a held newline, then a held control-Z.
                    type_next = aed_pkg::TYPE_CONSOLE;
                    byte_next = (step_reg == 2'd0) ? aed_pkg::BYTE_LF : aed_pkg::BYTE_CZ;
                    code_next = 5'd0;
                    last_next = (step_reg == head.replay - 2'd1) && !head.has_tail;
                end else begin
                    type_next = head.tail_type;
                    byte_next = head.tail_byte;
                    code_next = head.tail_code;
                    last_next = 1'b1;
                end
                if (last_next) begin
                    pop       = 1'b1;
                    step_next = 2'd0;
                end else begin
                    step_next = step_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            step_reg  <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk) begin
        type_reg <= type_next;
        byte_reg <= byte_next;
        code_reg <= code_next;
        last_reg <= last_next;
    end

    assign out_valid       = valid_reg;
    assign item_type       = type_reg;
    assign byte_value      = byte_reg;
    assign annotation_code = code_reg;
    assign last_of_run     = last_reg;

    // A partly expanded entry must still sit at the head of the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != 2'd0) |-> head_valid)
        else $error("aed_back: step advanced without a queued entry");

    // Only annotation-complete results carry a code, and they carry no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((type_reg == aed_pkg::TYPE_COMPLETE) ?
                       (byte_reg == 8'd0 && last_reg) : (code_reg == 5'd0)))
        else $error("aed_back: inconsistent result fields");

endmodule
